// ===== design/led_blink_pulse_indicator_unit_assert.svh =====
// ---------------------------------------------------------------------------
// LED indicator assertion macros
// Shared concurrent assertion wrappers; compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef LED_BLINK_PULSE_INDICATOR_UNIT_ASSERT_SVH
`define LED_BLINK_PULSE_INDICATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LBPI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("led indicator: implication check failed");

// next-cycle implication
`define LBPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("led indicator: next-cycle check failed");

// invariant
`define LBPI_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("led indicator: invariant check failed");

`else

`define LBPI_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define LBPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define LBPI_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

// ===== design/lbpi_pkg.sv =====
// ---------------------------------------------------------------------------
// LED indicator package
// Shared types, timing constants and register indexes.
// ---------------------------------------------------------------------------
package lbpi_pkg;

	localparam int unsigned OFF_MS          = 200;
	localparam int unsigned ON_MS           = 100;
	localparam int unsigned PULSE_CYCLE_MS  = 1000;
	localparam int unsigned UPDATE_MS       = 20;
	localparam int unsigned TICK_MOD        = PULSE_CYCLE_MS / 20;
	localparam int unsigned TICK_LIT        = PULSE_CYCLE_MS / 40;

	localparam int unsigned TICK_W      = 6;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned COUNT_W     = 8;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned S_TDATA_W   = 48;
	localparam int unsigned M_TDATA_W   = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERRIDE_ENABLE = 3'd0,
		REG_OVERRIDE_RED    = 3'd1,
		REG_OVERRIDE_GREEN  = 3'd2,
		REG_OVERRIDE_BLUE   = 3'd3,
		REG_ACTIVE_HIGH     = 3'd4,
		REG_GREEN_PRESENT   = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ON   = 2'd1,
		PH_OFF  = 2'd2
	} phase_t;

	typedef struct packed {
		logic       override_enable;
		logic [7:0] override_red;
		logic [7:0] override_green;
		logic [7:0] override_blue;
		logic       active_high;
		logic       green_present;
	} cfg_t;

	typedef struct packed {
		logic               mode;
		logic [TIME_W-1:0]  now_ms;
		logic               connected;
		logic [COUNT_W-1:0] prof_num;
	} item_t;

	typedef struct packed {
		logic drive_valid;
		logic red_level;
		logic green_level;
		logic blue_level;
		logic indicating;
	} result_t;

endpackage

// ===== design/lbpi_cfg.sv =====
// ---------------------------------------------------------------------------
// LED indicator configuration registers
// Write-only register file; writes to unlisted indexes are dropped.
// ---------------------------------------------------------------------------
module lbpi_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lbpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbpi_pkg::CFG_DATA_W-1:0]  cfg_data,
	output lbpi_pkg::cfg_t                   cfg
);

	lbpi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{green_present: 1'b1, default: '0};
		end else if (cfg_we) begin
			unique case (lbpi_pkg::reg_idx_t'(cfg_index))
				lbpi_pkg::REG_OVERRIDE_ENABLE: cfg_q.override_enable <= cfg_data[0];
				lbpi_pkg::REG_OVERRIDE_RED:    cfg_q.override_red    <= cfg_data;
				lbpi_pkg::REG_OVERRIDE_GREEN:  cfg_q.override_green  <= cfg_data;
				lbpi_pkg::REG_OVERRIDE_BLUE:   cfg_q.override_blue   <= cfg_data;
				lbpi_pkg::REG_ACTIVE_HIGH:     cfg_q.active_high     <= cfg_data[0];
				lbpi_pkg::REG_GREEN_PRESENT:   cfg_q.green_present   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/lbpi_core.sv =====
// ---------------------------------------------------------------------------
// LED indicator core
// Blink sequencer and rate-limited pulse state, one item per step.
// ---------------------------------------------------------------------------
`include "led_blink_pulse_indicator_unit_assert.svh"

module lbpi_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  lbpi_pkg::item_t     item,
	input  lbpi_pkg::cfg_t      cfg,
	output lbpi_pkg::result_t   res
);

	lbpi_pkg::phase_t                    phase_q, phase_d;
	logic [lbpi_pkg::COUNT_W-1:0]        blinks_q, blinks_d, blinks_dec;
	logic [lbpi_pkg::TIME_W-1:0]         start_q, start_d, last_q, last_d;
	logic [lbpi_pkg::TIME_W-1:0]         elapsed, since_update;
	logic [lbpi_pkg::TICK_W-1:0]         tick_q, tick_d, tick_inc;
	logic                                off_done, on_done, update_due, lit;
	logic                                want_r, want_g, want_b;

	assign elapsed      = item.now_ms - start_q;
	assign since_update = item.now_ms - last_q;
	assign off_done     = elapsed >= lbpi_pkg::TIME_W'(lbpi_pkg::OFF_MS);
	assign on_done      = elapsed >= lbpi_pkg::TIME_W'(lbpi_pkg::ON_MS);
	assign update_due   = since_update >= lbpi_pkg::TIME_W'(lbpi_pkg::UPDATE_MS);
	assign blinks_dec   = blinks_q - 1'b1;
	assign tick_inc     = (tick_q == lbpi_pkg::TICK_W'(lbpi_pkg::TICK_MOD - 1))
		? '0 : tick_q + 1'b1;
	assign lit          = item.connected || (tick_inc < lbpi_pkg::TICK_W'(lbpi_pkg::TICK_LIT));

	// next state
	always_comb begin
		phase_d  = phase_q;
		blinks_d = blinks_q;
		start_d  = start_q;
		last_d   = last_q;
		tick_d   = tick_q;
		if (step) begin
			if (item.mode) begin
				if (phase_q == lbpi_pkg::PH_IDLE) begin
					blinks_d = item.prof_num + 1'b1;
					phase_d  = lbpi_pkg::PH_OFF;
					start_d  = item.now_ms;
				end
			end else begin
				unique case (phase_q)
					lbpi_pkg::PH_OFF: begin
						if (off_done) begin
							blinks_d = blinks_dec;
							phase_d  = (blinks_dec != '0) ? lbpi_pkg::PH_ON : lbpi_pkg::PH_IDLE;
							start_d  = item.now_ms;
						end
					end
					lbpi_pkg::PH_ON: begin
						if (on_done) begin
							phase_d = lbpi_pkg::PH_OFF;
							start_d = item.now_ms;
						end
					end
					lbpi_pkg::PH_IDLE: begin
						if (update_due) begin
							last_d = item.now_ms;
							tick_d = tick_inc;
						end
					end
					default: phase_d = lbpi_pkg::PH_IDLE;
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		res             = '0;
		want_r          = 1'b0;
		want_g          = 1'b0;
		want_b          = 1'b0;
		if (!item.mode) begin
			unique case (phase_q)
				lbpi_pkg::PH_OFF: res.drive_valid = 1'b1;
				lbpi_pkg::PH_ON: begin
					res.drive_valid = 1'b1;
					want_r = !cfg.override_enable || (cfg.override_red   != '0);
					want_g = !cfg.override_enable || (cfg.override_green != '0);
					want_b = !cfg.override_enable || (cfg.override_blue  != '0);
				end
				lbpi_pkg::PH_IDLE: begin
					res.drive_valid = update_due;
					if (cfg.override_enable) begin
						want_r = lit && (cfg.override_red   != '0);
						want_g = lit && (cfg.override_green != '0);
						want_b = lit && (cfg.override_blue  != '0);
					end else begin
						want_b = lit;
					end
				end
				default: ;
			endcase
		end
		// pin level: lit XNOR polarity, zeros when nothing is driven
		if (res.drive_valid) begin
			res.red_level   = want_r ~^ cfg.active_high;
			res.green_level = (want_g && cfg.green_present) ~^ cfg.active_high;
			res.blue_level  = want_b ~^ cfg.active_high;
		end
		res.indicating = phase_d != lbpi_pkg::PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= lbpi_pkg::PH_IDLE;
			blinks_q <= '0;
			start_q  <= '0;
			last_q   <= '0;
			tick_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			blinks_q <= blinks_d;
			start_q  <= start_d;
			last_q   <= last_d;
			tick_q   <= tick_d;
		end
	end

	`LBPI_ASSERT_NEXT(a_start_enters_off, clk, arst_n,
		step && item.mode && (phase_q == lbpi_pkg::PH_IDLE), phase_q == lbpi_pkg::PH_OFF)
	`LBPI_ASSERT_IMPLY(a_on_has_blinks, clk, arst_n,
		phase_q == lbpi_pkg::PH_ON, blinks_q != '0)
	`LBPI_ASSERT_ALWAYS(a_tick_in_range, clk, arst_n,
		tick_q < lbpi_pkg::TICK_W'(lbpi_pkg::TICK_MOD))
	`LBPI_ASSERT_IMPLY(a_quiet_levels_zero, clk, arst_n,
		step && !res.drive_valid, !res.red_level && !res.green_level && !res.blue_level)

endmodule

// ===== design/led_blink_pulse_indicator_unit.sv =====
// ---------------------------------------------------------------------------
// LED blink / pulse indicator unit
// Streams timestamped service calls in, one LED pin update result out each.
// ---------------------------------------------------------------------------
// Pipeline: an input transfer is registered in the input register, and its
//   result is computed and registered in the result register, which drives
//   m_tvalid.
// Throughput: one item per cycle unless m_tready stalls the result register,
//   set by the single compute stage between the input and result registers.
// Reset (arst_n low, asynchronous): indicator idle, counters and timestamps
//   zero, pipeline empty, registers at defaults (green_present = 1).
module led_blink_pulse_indicator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave side
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tdata: now_ms[31:0], connected[32], prof_num[40:33], zero pad
	input  logic [lbpi_pkg::S_TDATA_W-1:0]   s_tdata,
	// tuser: mode[0]
	input  logic                             s_tuser,
	// master side
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata: red_level[0], green_level[1], blue_level[2], indicating[3], zero pad
	output logic [lbpi_pkg::M_TDATA_W-1:0]   m_tdata,
	// tuser: drive_valid[0]
	output logic                             m_tuser,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [lbpi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbpi_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lbpi_pkg::cfg_t     cfg;
	lbpi_pkg::item_t    item_s1;
	lbpi_pkg::result_t  res, res_s2;
	logic               valid_s1, valid_s2;
	logic               advance, step;

	// the result register frees up when empty or being taken downstream
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	// input register refills when empty or when its item moves on this cycle
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance)  valid_s2 <= valid_s1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode      <= s_tuser;
			item_s1.now_ms    <= s_tdata[31:0];
			item_s1.connected <= s_tdata[32];
			item_s1.prof_num  <= s_tdata[40:33];
		end
		if (step) res_s2 <= res;
	end

	lbpi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state advances only when the item's result is loaded
	lbpi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.drive_valid;
	assign m_tdata  = {4'b0000, res_s2.indicating, res_s2.blue_level,
		res_s2.green_level, res_s2.red_level};

endmodule

// ===== tb/sv/led_level_check_pkg.sv =====
// ---------------------------------------------------------------------------
// LED indicator level tracker
// Scoreboard class that mirrors the indicator state, predicts the pin levels
// of every accepted service call and compares them with the results.
// ---------------------------------------------------------------------------
package led_level_check_pkg;

	import lbpi_pkg::*;

	class led_level_tracker;
		cfg_t               regs;
		phase_t             phase;
		logic [COUNT_W-1:0] blinks_left;
		logic [TIME_W-1:0]  phase_t0;
		logic [TIME_W-1:0]  last_update;
		logic [TICK_W-1:0]  tick;
		result_t            expected_levels[$];
		int unsigned        mismatches;
		int unsigned        calls;
		int unsigned        updates;
		int unsigned        starts;
		int unsigned        busy_starts;

		function new();
			regs = '0;
			regs.green_present = 1'b1;
			phase = PH_IDLE;
			blinks_left = '0;
			phase_t0 = '0;
			last_update = '0;
			tick = '0;
			mismatches = 0;
			calls = 0;
			updates = 0;
			starts = 0;
			busy_starts = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			unique case (idx)
				REG_OVERRIDE_ENABLE: regs.override_enable = data[0];
				REG_OVERRIDE_RED:    regs.override_red = data;
				REG_OVERRIDE_GREEN:  regs.override_green = data;
				REG_OVERRIDE_BLUE:   regs.override_blue = data;
				REG_ACTIVE_HIGH:     regs.active_high = data[0];
				REG_GREEN_PRESENT:   regs.green_present = data[0];
				default: ;
			endcase
		endfunction

		// pin levels after polarity; green stays at the off level when absent
		function result_t pins(logic red, logic green, logic blue);
			result_t r;
			r = '0;
			r.drive_valid = 1'b1;
			r.red_level = red ? regs.active_high : !regs.active_high;
			r.green_level = (green && regs.green_present) ? regs.active_high
				: !regs.active_high;
			r.blue_level = blue ? regs.active_high : !regs.active_high;
			return r;
		endfunction

		function result_t colour_pins();
			return pins(regs.override_red != 0, regs.override_green != 0,
				regs.override_blue != 0);
		endfunction

		// predict the result of one accepted call and queue it
		function void note_call(logic mode, logic [TIME_W-1:0] now_ms, logic connected,
			logic [COUNT_W-1:0] prof_num);
			result_t           r;
			logic [TIME_W-1:0] elapsed;
			logic              lit;
			r = '0;
			elapsed = now_ms - phase_t0;
			calls++;
			if (mode) begin
				if (phase == PH_IDLE) begin
					// index 255 wraps to a count of 0, i.e. 256 counts (255 on phases)
					blinks_left = prof_num + 8'd1;
					phase = PH_OFF;
					phase_t0 = now_ms;
					starts++;
				end else begin
					busy_starts++;
				end
			end else if (phase == PH_OFF) begin
				r = pins(1'b0, 1'b0, 1'b0);
				if (elapsed >= OFF_MS) begin
					blinks_left = blinks_left - 8'd1;
					phase = (blinks_left != 0) ? PH_ON : PH_IDLE;
					phase_t0 = now_ms;
				end
			end else if (phase == PH_ON) begin
				r = regs.override_enable ? colour_pins() : pins(1'b1, 1'b1, 1'b1);
				if (elapsed >= ON_MS) begin
					phase = PH_OFF;
					phase_t0 = now_ms;
				end
			end else if (phase != PH_IDLE) begin
				// unused phase code drops back to idle, no drive
				phase = PH_IDLE;
			end else if (now_ms - last_update >= UPDATE_MS) begin
				last_update = now_ms;
				tick = TICK_W'((tick + 1) % TICK_MOD);
				lit = connected || (tick < TICK_LIT);
				if (regs.override_enable)
					r = lit ? colour_pins() : pins(1'b0, 1'b0, 1'b0);
				else
					r = pins(1'b0, 1'b0, lit);
			end
			if (r.drive_valid)
				updates++;
			r.indicating = (phase != PH_IDLE);
			expected_levels.push_back(r);
		endfunction

		function void compare(string field, logic want, logic got);
			if (want !== got) begin
				$error("%s mismatch: expected %0b, got %0b", field, want, got);
				mismatches++;
			end
		endfunction

		// check one result transfer against the oldest prediction
		function void check_update(logic drive_valid, logic [M_TDATA_W-1:0] levels);
			result_t want;
			if (expected_levels.size() == 0) begin
				$error("result transfer with no call outstanding: drive_valid %0b levels %h",
					drive_valid, levels);
				mismatches++;
				return;
			end
			want = expected_levels.pop_front();
			compare("drive_valid", want.drive_valid, drive_valid);
			compare("red_level", want.red_level, levels[0]);
			compare("green_level", want.green_level, levels[1]);
			compare("blue_level", want.blue_level, levels[2]);
			compare("indicating", want.indicating, levels[3]);
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_led_blink_pulse_indicator_unit.sv =====
// ---------------------------------------------------------------------------
// LED blink / pulse indicator testbench
// Streams timestamped service calls and blink starts into the unit, predicts
// every pin update with a scoreboard model and checks each result transfer.
// Covers time wrap, update throttling, pulse ticks, blink counts up to 256
// and several register settings, with random idling on both stream sides.
// ---------------------------------------------------------------------------
module tb_led_blink_pulse_indicator_unit;

	import lbpi_pkg::*;
	import led_level_check_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// tdata: now_ms[31:0], connected[32], prof_num[40:33], zero pad
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	// tuser: mode[0]
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// tdata: red_level[0], green_level[1], blue_level[2], indicating[3], zero pad
	logic [M_TDATA_W-1:0]  m_tdata;
	// tuser: drive_valid[0]
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_OVERRIDE_ENABLE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	led_level_tracker tracker = new();

	// tb view of the uptime counter
	logic [TIME_W-1:0] uptime = '0;
	// random idling switches; both go off for the final stretch
	bit                gaps_on = 1'b1;
	bit                stalls_on = 1'b1;
	int unsigned       programs = 0;

	led_blink_pulse_indicator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial forever #1 clk = ~clk;

	// hard stop in case the stream hangs
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: ready toggles in random bursts, with occasional stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			if (stalls_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// every result transfer goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_update(m_tuser, m_tdata);
	end

	// one call transfer; valid stays high across back-to-back calls,
	// with an occasional sender gap in front
	task automatic service_call(input logic mode, input logic [TIME_W-1:0] now_ms,
		input logic connected, input logic [COUNT_W-1:0] prof_num);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {7'b0, prof_num, connected, now_ms};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.note_call(mode, now_ms, connected, prof_num);
	endtask

	// stop sending and drain: every predicted result back, plus pipeline slack
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_levels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		tracker.set_reg(idx, data);
	endtask

	// full register program, only with the unit drained
	task automatic program_regs(input logic [7:0] en, input logic [7:0] red,
		input logic [7:0] green, input logic [7:0] blue, input logic [7:0] act_high,
		input logic [7:0] green_on);
		settle();
		write_reg(REG_OVERRIDE_ENABLE, en);
		write_reg(REG_OVERRIDE_RED, red);
		write_reg(REG_OVERRIDE_GREEN, green);
		write_reg(REG_OVERRIDE_BLUE, blue);
		write_reg(REG_ACTIVE_HIGH, act_high);
		write_reg(REG_GREEN_PRESENT, green_on);
		cfg_we <= 1'b0;
		@(posedge clk);
		programs++;
	endtask

	// periodic calls with steps around the 20 ms throttle
	task automatic service_burst(input int unsigned count);
		logic        conn;
		int unsigned pick;
		conn = 1'($urandom_range(0, 1));
		repeat (count) begin
			pick = $urandom_range(0, 9);
			unique case (pick)
				0: uptime += $urandom_range(0, 19);
				1: uptime += UPDATE_MS;
				2: uptime += UPDATE_MS - 1;
				default: uptime += $urandom_range(15, 45);
			endcase
			if ($urandom_range(0, 7) == 0)
				conn = !conn;
			service_call(1'b0, uptime, conn, COUNT_W'($urandom_range(0, 255)));
		end
	endtask

	// start an indication and keep calling until it is over; steps land on
	// and around the off/on phase lengths, with starts while busy mixed in
	task automatic blink_run(input logic [COUNT_W-1:0] prof_num);
		int unsigned pick;
		uptime += $urandom_range(0, 50);
		service_call(1'b1, uptime, 1'($urandom_range(0, 1)), prof_num);
		while (tracker.phase != PH_IDLE) begin
			pick = $urandom_range(0, 11);
			unique case (pick)
				0: uptime += $urandom_range(0, 30);
				1: uptime += ON_MS - 1;
				2: uptime += ON_MS;
				3: uptime += OFF_MS - 1;
				4: uptime += OFF_MS;
				5: uptime += $urandom_range(1, 60);
				6: uptime += $urandom;
				default: uptime += $urandom_range(50, 250);
			endcase
			if (pick == 0)
				service_call(1'b1, uptime, 1'($urandom_range(0, 1)),
					COUNT_W'($urandom_range(0, 255)));
			else
				service_call(1'b0, uptime, 1'($urandom_range(0, 1)),
					COUNT_W'($urandom_range(0, 255)));
		end
	endtask

	// stray call: arbitrary uptime jump (often near the 32-bit wrap)
	task automatic stray_call();
		logic mode;
		logic [COUNT_W-1:0] idx;
		mode = 1'($urandom_range(0, 1));
		idx = COUNT_W'($urandom_range(0, 255));
		// keep fresh indications short so throttled bursts can finish them
		if (mode && tracker.phase == PH_IDLE)
			idx = COUNT_W'($urandom_range(0, 3));
		if ($urandom_range(0, 1))
			uptime = $urandom;
		else
			uptime = 32'hFFFF_FFC0 + $urandom_range(0, 63);
		service_call(mode, uptime, 1'($urandom_range(0, 1)), idx);
	endtask

	initial begin
		int unsigned base;
		int unsigned roll;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values (override off, active low)
		service_call(1'b0, 32'd0, 1'b0, 8'h00);          // no time passed: no update
		service_call(1'b0, 32'd19, 1'b0, 8'hFF);         // just under the throttle
		service_call(1'b0, 32'd20, 1'b0, 8'h00);         // first pulse tick
		service_call(1'b0, 32'hFFFF_FFFF, 1'b1, 8'hAA);  // top of the uptime range
		service_call(1'b0, 32'd19, 1'b1, 8'h55);         // 20 ms across the wrap
		service_call(1'b1, 32'd100, 1'b0, 8'h00);        // one count, ends after off
		service_call(1'b1, 32'd150, 1'b1, 8'hFF);        // start while busy, dropped
		service_call(1'b0, 32'd299, 1'b1, 8'h00);        // off phase 1 ms short
		service_call(1'b0, 32'd300, 1'b0, 8'h00);        // off phase done, idle
		service_call(1'b1, 32'd400, 1'b0, 8'h01);        // two counts
		service_call(1'b0, 32'd600, 1'b0, 8'h00);        // off -> on
		service_call(1'b0, 32'd699, 1'b1, 8'h00);        // on, white
		service_call(1'b0, 32'd700, 1'b0, 8'h00);        // on -> off
		service_call(1'b0, 32'd900, 1'b0, 8'h00);        // off done, idle
		service_call(1'b0, 32'd905, 1'b0, 8'h00);        // throttle measured from 19
		// profile index 255: count wraps, 256 counts (255 on phases); each call lands
		// exactly on the phase length, so every call moves the phase on
		uptime = 32'd1000;
		service_call(1'b1, uptime, 1'b0, 8'hFF);
		while (tracker.phase != PH_IDLE) begin
			uptime += (tracker.phase == PH_OFF) ? OFF_MS : ON_MS;
			service_call(1'b0, uptime, 1'b1, 8'h00);
		end

		// random part, six register settings; each one starts from a drained
		// unit, so the sender also pauses until all results are back
		base = tracker.calls;
		for (int p = 0; p < 6; p++) begin
			unique case (p)
				0: program_regs(8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h01);
				1: program_regs(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
				2: program_regs(8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'h01, 8'h00);
				4: program_regs(8'h01, 8'h01, 8'h80, 8'h00, 8'h01, 8'h01);
				// full random bytes, upper bits of the 1-bit registers dropped
				default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			if (p == 5) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			while (tracker.calls < base + (p + 1) * 85) begin
				roll = $urandom_range(0, 9);
				if (roll < 5)
					service_burst($urandom_range(4, 30));
				else if (roll < 8)
					blink_run(COUNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(5, 15)
						: $urandom_range(0, 4)));
				else
					stray_call();
			end
		end

		settle();
		$display("Ran %0d calls: %0d pin updates, %0d indications, %0d starts while busy.",
			tracker.calls, tracker.updates, tracker.starts, tracker.busy_starts);
		$display("%0d register programs: override on/off, both polarities, green absent.",
			programs);
		if (tracker.mismatches == 0 && tracker.expected_levels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
